>>> hdl/top_down_region_allocator_core_macros.svh
// Assertion macros for the top-down region allocator core.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef TOP_DOWN_REGION_ALLOCATOR_CORE_MACROS_SVH
`define TOP_DOWN_REGION_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TDRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TDRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tdra_pkg.sv
// Shared types and codes for the top-down region allocator.
// No dependencies; imported by top_down_region_allocator_core.
package tdra_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [2:0] KIND_FREE     = 3'd0;
  localparam logic [2:0] KIND_OCCUPIED = 3'd1;
  localparam logic [2:0] KIND_OLD      = 3'd2;
  localparam logic [2:0] KIND_NVS      = 3'd3;

  localparam logic [7:0] FW_USABLE   = 8'd1;
  localparam logic [7:0] FW_RESERVED = 8'd2;

  localparam logic [31:0] MIN_BASE_RST = 32'h0010_0000;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [7:0]  fw_type;
    logic [2:0]  kind;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHRINK,
    S_APPEND,
    S_RDOUT
  } state_t;

  function automatic logic [7:0] pool_fw(input logic [1:0] pool);
    logic [7:0] fw;
    unique case (pool)
      2'd0, 2'd1: fw = FW_USABLE;
      default:    fw = FW_RESERVED;
    endcase
    return fw;
  endfunction

  function automatic logic [2:0] pool_kd(input logic [1:0] pool);
    logic [2:0] kd;
    unique case (pool)
      2'd1:    kd = KIND_OLD;
      2'd3:    kd = KIND_NVS;
      default: kd = KIND_OCCUPIED;
    endcase
    return kd;
  endfunction

endpackage

>>> hdl/top_down_region_allocator_core.sv
// Top-down first-fit region allocator: region table, scan sequencer and result register.
// Depends on tdra_pkg and top_down_region_allocator_core_macros.svh.
//
//  channel  handshake                 transfer when             payload
//  -------  ------------------------  ------------------------  ------------------------------
//  in       start / busy              start && !busy            in_command .. in_entry_index
//  out      out_valid (strobe)        every out_valid cycle     out_status .. out_entry_count
//  cfg      cfg_valid / cfg_ready     cfg_valid && cfg_ready    cfg_data (min_base_address)
//
// Load and unused commands: result strobe the cycle after the transfer.
// Read: the entry passes the registered read port of the table memory, then the result register.
// Allocate: the scan reads one entry a cycle, newest first, through the single read port of the table,
//   then shrinks the hit region and appends the new entry, unless the table is full.
// Reset clears control state only; the table needs no clearing pass, as no unwritten entry
//   is ever read. The receiver cannot stall: each result shows for exactly one cycle.
`include "top_down_region_allocator_core_macros.svh"

module top_down_region_allocator_core
  import tdra_pkg::*;
#(
  parameter int TABLE_ENTRIES = 128,
  parameter int PAGE_BYTES    = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_region_base,
  input  logic [63:0] in_region_length,
  input  logic [7:0]  in_region_fw_type,
  input  logic [2:0]  in_region_kind_in,
  input  logic [20:0] in_page_count,
  input  logic [1:0]  in_pool_kind,
  input  logic [6:0]  in_entry_index,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_alloc_address,
  output logic [63:0] out_entry_base,
  output logic [63:0] out_entry_length,
  output logic [7:0]  out_entry_fw_type,
  output logic [2:0]  out_entry_kind,
  output logic [7:0]  out_entry_count,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int PB_W  = $clog2(PAGE_BYTES + 1);
  localparam int SZ_W  = 21 + PB_W;

  // table memory: one write and one registered read per cycle
  entry_t             mem [TABLE_ENTRIES];
  entry_t             rd_data_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [31:0]        min_base_r;

  logic [SZ_W-1:0]    size_r, size_nxt, size_prod;
  logic [1:0]         pool_r, pool_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic               issue_more_r, issue_more_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  entry_t             hit_ent_r, hit_ent_nxt;
  logic [63:0]        new_len_r, new_len_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [31:0]        addr_r, addr_nxt;
  entry_t             ent_out_r, ent_out_nxt;

  logic               accept;
  logic               full;
  logic               in_range;
  logic               hit;
  logic [63:0]        top_addr;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign full      = (count_r == CNT_W'(TABLE_ENTRIES));
  assign in_range  = (32'(in_entry_index) < 32'(count_r));
  assign size_prod = SZ_W'(in_page_count) * SZ_W'(PAGE_BYTES);
  assign top_addr  = hit_ent_r.base + new_len_r;

  // entry under check fits: free, long enough, at or above the minimum base
  assign hit = chk_vld_r && (rd_data_r.kind == KIND_FREE)
               && (rd_data_r.length >= 64'(size_r))
               && (rd_data_r.base >= 64'(min_base_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_ALLOC: begin
              if ((in_page_count != '0) && (count_r != '0)) state_nxt = S_SCAN;
            end
            CMD_READ: begin
              if (in_range) state_nxt = S_RDOUT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = full ? S_IDLE : S_SHRINK;
        end else if (chk_vld_r && !issue_more_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_SHRINK: state_nxt = S_APPEND;
      S_APPEND: state_nxt = S_IDLE;
      S_RDOUT:  state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    count_nxt      = count_r;
    size_nxt       = size_r;
    pool_nxt       = pool_r;
    scan_idx_nxt   = scan_idx_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    issue_more_nxt = issue_more_r;
    hit_idx_nxt    = hit_idx_r;
    hit_ent_nxt    = hit_ent_r;
    new_len_nxt    = new_len_r;
    out_valid_nxt  = 1'b0;
    status_nxt     = status_r;
    addr_nxt       = addr_r;
    ent_out_nxt    = ent_out_r;
    rd_addr        = scan_idx_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[IDX_W-1:0];
    wr_data        = '0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = IDX_W'(in_entry_index);
        if (accept) begin
          size_nxt       = size_prod;
          pool_nxt       = in_pool_kind;
          scan_idx_nxt   = IDX_W'(count_r - 1'b1);
          chk_vld_nxt    = 1'b0;
          issue_more_nxt = 1'b1;
          status_nxt     = ST_OK;
          addr_nxt       = '0;
          ent_out_nxt    = '0;
          case (in_command)
            CMD_LOAD: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_data   = '{base: in_region_base, length: in_region_length,
                              fw_type: in_region_fw_type, kind: in_region_kind_in};
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_ALLOC: begin
              if ((in_page_count == '0) || (count_r == '0)) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_NOMEM;
              end
            end
            CMD_READ: begin
              if (!in_range) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_RANGE;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        // issue the next read while checking the previous one
        if (issue_more_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_idx_r;
          if (scan_idx_r == '0) begin
            issue_more_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r - 1'b1;
          end
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (hit) begin
          hit_idx_nxt = chk_idx_r;
          hit_ent_nxt = rd_data_r;
          if (full) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_FULL;
          end
        end else if (chk_vld_r && !issue_more_r) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_NOMEM;
        end
      end
      S_SHRINK: begin
        new_len_nxt = hit_ent_r.length - 64'(size_r);
        wr_en       = 1'b1;
        wr_addr     = hit_idx_r;
        wr_data     = '{base: hit_ent_r.base, length: new_len_nxt,
                        fw_type: hit_ent_r.fw_type, kind: hit_ent_r.kind};
      end
      S_APPEND: begin
        wr_en         = 1'b1;
        wr_data       = '{base: top_addr, length: 64'(size_r),
                          fw_type: pool_fw(pool_r), kind: pool_kd(pool_r)};
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        addr_nxt      = top_addr[31:0];
      end
      S_RDOUT: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        ent_out_nxt   = rd_data_r;
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      min_base_r   <= MIN_BASE_RST;
      chk_vld_r    <= 1'b0;
      issue_more_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      chk_vld_r    <= chk_vld_nxt;
      issue_more_r <= issue_more_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        min_base_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    pool_r     <= pool_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    new_len_r  <= new_len_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
    ent_out_r  <= ent_out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_alloc_address = addr_r;
  assign out_entry_base    = ent_out_r.base;
  assign out_entry_length  = ent_out_r.length;
  assign out_entry_fw_type = ent_out_r.fw_type;
  assign out_entry_kind    = ent_out_r.kind;
  assign out_entry_count   = 8'(count_r);

  // every transfer either strobes a result next cycle or leaves the block busy
  `TDRA_ASSERT_NEXT(a_accept_progress, accept, busy || out_valid, "transfer neither answered nor busy")
  // a result only follows a transfer or work in progress
  `TDRA_ASSERT_NEXT(a_no_stray_result, !accept && !busy, !out_valid, "result without a command")
  // the table count never passes the table depth
  `TDRA_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(TABLE_ENTRIES), "entry count beyond depth")
  // a scan only runs over a non-empty table
  `TDRA_ASSERT_NOW(a_scan_nonempty, state_r == S_SCAN, count_r != '0, "scan over empty table")

endmodule
